FILE: rtl/core/etl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types, token codes and character helpers for the expression lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int POS_W           = 16;
  localparam int VALUE_W         = 31;
  localparam int KIND_W          = 4;
  localparam int CHAR_W          = 8;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // token kinds
  localparam logic [KIND_W-1:0] KIND_NUM  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LPAR = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RPAR = 4'd6;
  localparam logic [KIND_W-1:0] KIND_LT   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_GT   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_EQ   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_NE   = 4'd10;
  localparam logic [KIND_W-1:0] KIND_LE   = 4'd11;
  localparam logic [KIND_W-1:0] KIND_GE   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_END  = 4'd13;
  localparam logic [KIND_W-1:0] KIND_ERR  = 4'd14;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

  // what the lexer is holding back, waiting on the next character
  typedef enum logic [5:0] {
    MODE_NONE = 6'b000001,
    MODE_NUM  = 6'b000010,
    MODE_LT   = 6'b000100,
    MODE_GT   = 6'b001000,
    MODE_EQ   = 6'b010000,
    MODE_BANG = 6'b100000
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [VALUE_W-1:0] acc;
    logic               sat;
    logic               disc;
  } lex_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               ovf;
    logic               last;
  } token_t;

  localparam lex_state_t STATE_RESET = '{mode: MODE_NONE, acc: '0, sat: 1'b0, disc: 1'b0};

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic token_t mk_tok(input logic [KIND_W-1:0] kind,
                                    input logic [POS_W-1:0]  pos);
    token_t t;
    t.kind  = kind;
    t.value = '0;
    t.pos   = pos;
    t.ovf   = 1'b0;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

FILE: rtl/core/etl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_step
// One-character lexer step: from the current state and a character, the
// next state and up to two tokens (flushed pending token, then own token).
// ----------------------------------------------------------------------------
module etl_step #(
  parameter int OFFSET_BITS = etl_pkg::OFFSET_BITS_DEF
) (
  input  logic [etl_pkg::CHAR_W-1:0] ch,
  input  etl_pkg::lex_state_t        st,
  input  logic [OFFSET_BITS-1:0]     offset,
  input  logic [OFFSET_BITS-1:0]     start,
  output etl_pkg::lex_state_t        st_nxt,
  output logic [OFFSET_BITS-1:0]     offset_nxt,
  output logic [OFFSET_BITS-1:0]     start_nxt,
  output etl_pkg::token_t            tok0,
  output etl_pkg::token_t            tok1,
  output logic [1:0]                 tok_cnt
);

  logic [etl_pkg::POS_W-1:0] off_pos;
  logic [etl_pkg::POS_W-1:0] start_pos;

  generate
    if (OFFSET_BITS >= etl_pkg::POS_W) begin : g_pos_trunc
      assign off_pos   = offset[etl_pkg::POS_W-1:0];
      assign start_pos = start[etl_pkg::POS_W-1:0];
    end else begin : g_pos_ext
      assign off_pos   = {{(etl_pkg::POS_W-OFFSET_BITS){1'b0}}, offset};
      assign start_pos = {{(etl_pkg::POS_W-OFFSET_BITS){1'b0}}, start};
    end
  endgenerate

  // acc * 10 + digit, as shifts; wide enough that saturation is a plain compare
  logic [etl_pkg::VALUE_W+3:0] acc_ext;
  logic [etl_pkg::VALUE_W+3:0] acc_next_raw;
  logic                        acc_over;

  assign acc_ext      = {4'b0000, st.acc};
  assign acc_next_raw = (acc_ext << 3) + (acc_ext << 1)
                      + {{(etl_pkg::VALUE_W){1'b0}}, ch[3:0]};
  assign acc_over     = acc_next_raw > {4'b0000, etl_pkg::VALUE_MAX};

  always_comb begin
    etl_pkg::token_t flush_tok;
    etl_pkg::token_t own_tok;
    logic            flush_v;
    logic            own_v;
    logic            fresh;
    logic            is_eq;

    st_nxt     = st;
    start_nxt  = start;
    offset_nxt = offset + 1'b1;
    flush_tok  = etl_pkg::mk_tok(etl_pkg::KIND_ERR, start_pos);
    own_tok    = etl_pkg::mk_tok(etl_pkg::KIND_END, off_pos);
    flush_v    = 1'b0;
    own_v      = 1'b0;
    fresh      = 1'b1;
    is_eq      = (ch == etl_pkg::CH_EQ);

    if (st.disc) begin
      fresh = 1'b0;
      if (ch == etl_pkg::CH_NUL) begin
        own_v      = 1'b1;
        st_nxt     = etl_pkg::STATE_RESET;
        start_nxt  = '0;
        offset_nxt = '0;
      end
    end else begin
      unique case (st.mode)
        etl_pkg::MODE_NUM: begin
          if (etl_pkg::is_digit(ch)) begin
            fresh = 1'b0;
            if (acc_over) begin
              st_nxt.acc = etl_pkg::VALUE_MAX;
              st_nxt.sat = 1'b1;
            end else begin
              st_nxt.acc = acc_next_raw[etl_pkg::VALUE_W-1:0];
            end
          end else begin
            flush_v         = 1'b1;
            flush_tok.kind  = etl_pkg::KIND_NUM;
            flush_tok.value = st.acc;
            flush_tok.ovf   = st.sat;
            st_nxt.mode     = etl_pkg::MODE_NONE;
          end
        end
        etl_pkg::MODE_LT, etl_pkg::MODE_GT: begin
          flush_v     = 1'b1;
          st_nxt.mode = etl_pkg::MODE_NONE;
          fresh       = !is_eq;
          if (st.mode == etl_pkg::MODE_LT) begin
            flush_tok.kind = is_eq ? etl_pkg::KIND_LE : etl_pkg::KIND_LT;
          end else begin
            flush_tok.kind = is_eq ? etl_pkg::KIND_GE : etl_pkg::KIND_GT;
          end
        end
        etl_pkg::MODE_EQ, etl_pkg::MODE_BANG: begin
          flush_v     = 1'b1;
          st_nxt.mode = etl_pkg::MODE_NONE;
          if (is_eq) begin
            fresh          = 1'b0;
            flush_tok.kind = (st.mode == etl_pkg::MODE_EQ) ? etl_pkg::KIND_EQ
                                                             : etl_pkg::KIND_NE;
          end else if (ch != etl_pkg::CH_NUL) begin
            // lone '=' or '!': error, and characters are thrown away up to the terminator
            fresh       = 1'b0;
            st_nxt.disc = 1'b1;
          end
        end
        default: begin
          st_nxt.mode = etl_pkg::MODE_NONE;
        end
      endcase
    end

    if (fresh) begin
      if (ch == etl_pkg::CH_NUL) begin
        own_v      = 1'b1;
        st_nxt     = etl_pkg::STATE_RESET;
        start_nxt  = '0;
        offset_nxt = '0;
      end else if (etl_pkg::is_space(ch)) begin
        own_v = 1'b0;
      end else if (ch == etl_pkg::CH_PLUS) begin
        own_v = 1'b1; own_tok.kind = etl_pkg::KIND_ADD;
      end else if (ch == etl_pkg::CH_MINUS) begin
        own_v = 1'b1; own_tok.kind = etl_pkg::KIND_SUB;
      end else if (ch == etl_pkg::CH_STAR) begin
        own_v = 1'b1; own_tok.kind = etl_pkg::KIND_MUL;
      end else if (ch == etl_pkg::CH_SLASH) begin
        own_v = 1'b1; own_tok.kind = etl_pkg::KIND_DIV;
      end else if (ch == etl_pkg::CH_LPAR) begin
        own_v = 1'b1; own_tok.kind = etl_pkg::KIND_LPAR;
      end else if (ch == etl_pkg::CH_RPAR) begin
        own_v = 1'b1; own_tok.kind = etl_pkg::KIND_RPAR;
      end else if (ch == etl_pkg::CH_LT) begin
        st_nxt.mode = etl_pkg::MODE_LT;   start_nxt = offset;
      end else if (ch == etl_pkg::CH_GT) begin
        st_nxt.mode = etl_pkg::MODE_GT;   start_nxt = offset;
      end else if (ch == etl_pkg::CH_EQ) begin
        st_nxt.mode = etl_pkg::MODE_EQ;   start_nxt = offset;
      end else if (ch == etl_pkg::CH_BANG) begin
        st_nxt.mode = etl_pkg::MODE_BANG; start_nxt = offset;
      end else if (etl_pkg::is_digit(ch)) begin
        st_nxt.mode = etl_pkg::MODE_NUM;
        st_nxt.acc  = {{(etl_pkg::VALUE_W-4){1'b0}}, ch[3:0]};
        st_nxt.sat  = 1'b0;
        start_nxt   = offset;
      end else begin
        own_v        = 1'b1;
        own_tok.kind = etl_pkg::KIND_ERR;
        st_nxt.disc  = 1'b1;
      end
    end

    // order results: flushed token first, own token second
    tok1      = own_tok;
    tok1.last = 1'b1;
    if (flush_v) begin
      tok0      = flush_tok;
      tok0.last = !own_v;
    end else begin
      tok0      = own_tok;
      tok0.last = 1'b1;
    end
    tok_cnt = {1'b0, flush_v} + {1'b0, own_v};
  end

endmodule

FILE: rtl/core/expression_token_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_token_lexer_core
// Character-serial tokenizer for arithmetic expressions with a four-entry
// result queue on the output side.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  in_      in   in_tvalid / in_tready     tdata[7:0] char_code
//  out_     out  out_tvalid / out_tready   tuser token_kind, tdata value/pos/ovf,
//                                          tlast last_of_run
//
//  One character is taken per cycle while in_tready is high; its tokens land
//  in the result queue at the same edge and can leave from the next cycle on,
//  one per cycle while out_tready is high. A character that gives two tokens
//  (flush plus its own) needs two output transfers, so such a run is output-bound.
//  in_tready is low while fewer than two queue entries are free.
//  rst_n (synchronous) empties the queue and returns the lexer to offset 0.
// ----------------------------------------------------------------------------
module expression_token_lexer_core #(
  parameter int OFFSET_BITS = etl_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [30:0] token_value, [46:31] token_position,
                                  // [47] value_overflow
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  etl_pkg::lex_state_t     st_r, st_nxt;
  logic [OFFSET_BITS-1:0]  offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0]  start_r, start_nxt;
  etl_pkg::token_t         tok0, tok1;
  logic [1:0]              tok_cnt;

  etl_pkg::token_t         q_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    in_xfer, out_xfer;
  logic [1:0]              push;
  logic [QPTR_W-1:0]       wr_ptr_p1;
  etl_pkg::token_t         head;

  etl_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .ch         (in_tdata),
    .st         (st_r),
    .offset     (offset_r),
    .start      (start_r),
    .st_nxt     (st_nxt),
    .offset_nxt (offset_nxt),
    .start_nxt  (start_nxt),
    .tok0       (tok0),
    .tok1       (tok1),
    .tok_cnt    (tok_cnt)
  );

  assign in_tready = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = cnt_r != '0;
  assign out_xfer  = out_tvalid && out_tready;
  assign push      = in_xfer ? tok_cnt : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign cnt_nxt   = cnt_r + QCNT_W'(push) - QCNT_W'(out_xfer);

  assign head       = q_r[rd_ptr_r];
  assign out_tuser  = head.kind;
  assign out_tdata  = {head.ovf, head.pos, head.value};
  assign out_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= etl_pkg::STATE_RESET;
      offset_r <= '0;
      start_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_xfer) begin
        st_r     <= st_nxt;
        offset_r <= offset_nxt;
        start_r  <= start_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push);
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      q_r[wr_ptr_r] <= tok0;
    end
    if (push == 2'd2) begin
      q_r[wr_ptr_p1] <= tok1;
    end
  end

  // ---- assertions ----
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count beyond depth");

  a_term_clears_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tdata == etl_pkg::CH_NUL) |=> (offset_r == '0 && !st_r.disc))
    else $error("terminator did not restart the lexer");

  a_ovf_only_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[47]) |-> out_tuser == etl_pkg::KIND_NUM)
    else $error("overflow flag on a non-number token");

  a_value_only_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != etl_pkg::KIND_NUM) |-> out_tdata[30:0] == '0)
    else $error("nonzero value on a non-number token");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams expression strings into expression_token_lexer_core one character
// per transfer, predicts the token stream in a local lexer model and checks
// every token that leaves, under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;
  logic recv_hold      = 1'b0;
  int   chars_sent     = 0;
  int   mismatch_count = 0;
  int   stall_cycles   = 0;

  // tokens predicted but not yet seen on the output
  etl_pkg::token_t tokens_due[$];

  // lexer state mirror
  etl_pkg::mode_t              lx_mode    = etl_pkg::MODE_NONE;
  logic [etl_pkg::VALUE_W-1:0] lx_acc     = '0;
  logic                        lx_sat     = 1'b0;
  logic [etl_pkg::POS_W-1:0]   lx_start   = '0;
  logic [etl_pkg::POS_W-1:0]   lx_offset  = '0;
  logic                        lx_discard = 1'b0;

  expression_token_lexer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic etl_pkg::token_t make_token(
      input logic [etl_pkg::KIND_W-1:0]  kind,
      input logic [etl_pkg::VALUE_W-1:0] value,
      input logic [etl_pkg::POS_W-1:0]   pos,
      input logic                        ovf);
    etl_pkg::token_t t;
    t.kind  = kind;
    t.value = value;
    t.pos   = pos;
    t.ovf   = ovf;
    t.last  = 1'b0;
    return t;
  endfunction

  // advance the lexer mirror by one character and queue the tokens it yields
  function automatic void lex_char(input logic [7:0] c);
    etl_pkg::token_t                found[$];
    logic [etl_pkg::POS_W-1:0]      here;
    logic [etl_pkg::KIND_W-1:0]     kind;
    logic [34:0]                    grown;
    logic                           fresh;
    logic                           ended;
    logic                           digit;
    here  = lx_offset;
    fresh = 1'b1;
    ended = 1'b0;
    digit = (c >= etl_pkg::CH_ZERO) && (c <= etl_pkg::CH_NINE);
    if (lx_discard) begin
      fresh = 1'b0;
      ended = (c == etl_pkg::CH_NUL);
    end else begin
      case (lx_mode)
        etl_pkg::MODE_NUM: begin
          if (digit) begin
            grown = {4'b0000, lx_acc} * 35'd10 + 35'(c - etl_pkg::CH_ZERO);
            if (grown > {4'b0000, etl_pkg::VALUE_MAX}) begin
              grown  = {4'b0000, etl_pkg::VALUE_MAX};
              lx_sat = 1'b1;
            end
            lx_acc = grown[etl_pkg::VALUE_W-1:0];
            fresh  = 1'b0;
          end else begin
            found.push_back(make_token(etl_pkg::KIND_NUM, lx_acc, lx_start, lx_sat));
            lx_mode = etl_pkg::MODE_NONE;
          end
        end
        etl_pkg::MODE_LT, etl_pkg::MODE_GT: begin
          if (c == etl_pkg::CH_EQ) begin
            kind  = (lx_mode == etl_pkg::MODE_LT) ? etl_pkg::KIND_LE : etl_pkg::KIND_GE;
            fresh = 1'b0;
          end else begin
            kind = (lx_mode == etl_pkg::MODE_LT) ? etl_pkg::KIND_LT : etl_pkg::KIND_GT;
          end
          found.push_back(make_token(kind, '0, lx_start, 1'b0));
          lx_mode = etl_pkg::MODE_NONE;
        end
        etl_pkg::MODE_EQ, etl_pkg::MODE_BANG: begin
          if (c == etl_pkg::CH_EQ) begin
            kind  = (lx_mode == etl_pkg::MODE_EQ) ? etl_pkg::KIND_EQ : etl_pkg::KIND_NE;
            fresh = 1'b0;
            found.push_back(make_token(kind, '0, lx_start, 1'b0));
          end else begin
            found.push_back(make_token(etl_pkg::KIND_ERR, '0, lx_start, 1'b0));
            // terminator still ends the string normally
            if (c != etl_pkg::CH_NUL) begin
              lx_discard = 1'b1;
              fresh      = 1'b0;
            end
          end
          lx_mode = etl_pkg::MODE_NONE;
        end
        default: begin
        end
      endcase
    end

    if (fresh) begin
      if (c == etl_pkg::CH_NUL) begin
        ended = 1'b1;
      end else if (c == etl_pkg::CH_SPACE ||
                   (c >= etl_pkg::CH_TAB && c <= etl_pkg::CH_CR)) begin
      end else if (c == etl_pkg::CH_PLUS) begin
        found.push_back(make_token(etl_pkg::KIND_ADD, '0, here, 1'b0));
      end else if (c == etl_pkg::CH_MINUS) begin
        found.push_back(make_token(etl_pkg::KIND_SUB, '0, here, 1'b0));
      end else if (c == etl_pkg::CH_STAR) begin
        found.push_back(make_token(etl_pkg::KIND_MUL, '0, here, 1'b0));
      end else if (c == etl_pkg::CH_SLASH) begin
        found.push_back(make_token(etl_pkg::KIND_DIV, '0, here, 1'b0));
      end else if (c == etl_pkg::CH_LPAR) begin
        found.push_back(make_token(etl_pkg::KIND_LPAR, '0, here, 1'b0));
      end else if (c == etl_pkg::CH_RPAR) begin
        found.push_back(make_token(etl_pkg::KIND_RPAR, '0, here, 1'b0));
      end else if (c == etl_pkg::CH_LT || c == etl_pkg::CH_GT ||
                   c == etl_pkg::CH_EQ || c == etl_pkg::CH_BANG) begin
        lx_mode  = (c == etl_pkg::CH_LT) ? etl_pkg::MODE_LT
                 : (c == etl_pkg::CH_GT) ? etl_pkg::MODE_GT
                 : (c == etl_pkg::CH_EQ) ? etl_pkg::MODE_EQ : etl_pkg::MODE_BANG;
        lx_start = here;
      end else if (digit) begin
        lx_mode  = etl_pkg::MODE_NUM;
        lx_acc   = {{(etl_pkg::VALUE_W-8){1'b0}}, c - etl_pkg::CH_ZERO};
        lx_sat   = 1'b0;
        lx_start = here;
      end else begin
        found.push_back(make_token(etl_pkg::KIND_ERR, '0, here, 1'b0));
        lx_discard = 1'b1;
      end
    end

    if (ended) begin
      found.push_back(make_token(etl_pkg::KIND_END, '0, here, 1'b0));
      lx_mode    = etl_pkg::MODE_NONE;
      lx_acc     = '0;
      lx_sat     = 1'b0;
      lx_start   = '0;
      lx_offset  = '0;
      lx_discard = 1'b0;
    end else begin
      lx_offset = here + 1'b1;
    end

    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) tokens_due.push_back(found[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(etl_pkg::CH_NUL);
  endtask

  task automatic send_random_text();
    logic [7:0] text[$];
    int         pieces;
    int         pick;
    int         len;
    pieces = $urandom_range(1, 12);
    repeat (pieces) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // mostly short numbers, now and then long enough to saturate
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12)
                                           : $urandom_range(1, 4);
        repeat (len) text.push_back(8'(etl_pkg::CH_ZERO + $urandom_range(0, 9)));
      end else if (pick < 60) begin
        case ($urandom_range(0, 5))
          0:       text.push_back(etl_pkg::CH_PLUS);
          1:       text.push_back(etl_pkg::CH_MINUS);
          2:       text.push_back(etl_pkg::CH_STAR);
          3:       text.push_back(etl_pkg::CH_SLASH);
          4:       text.push_back(etl_pkg::CH_LPAR);
          default: text.push_back(etl_pkg::CH_RPAR);
        endcase
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       text.push_back(etl_pkg::CH_LT);
          1:       text.push_back(etl_pkg::CH_GT);
          2:       text.push_back(etl_pkg::CH_EQ);
          default: text.push_back(etl_pkg::CH_BANG);
        endcase
        if ($urandom_range(0, 9) < 7) text.push_back(etl_pkg::CH_EQ);
      end else if (pick < 90) begin
        text.push_back(($urandom_range(0, 6) == 0) ? etl_pkg::CH_SPACE
                       : 8'(etl_pkg::CH_TAB + $urandom_range(0, 4)));
      end else begin
        text.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (text[i]) send_char(text[i]);
    send_char(etl_pkg::CH_NUL);
  endtask

  task automatic test_operators();
    // lone '<' flushed by a digit, lone '>' flushed by the terminator
    send_text("(+-*/)<1>");
  endtask

  task automatic test_comparisons();
    send_text("<=>=!===");
  endtask

  task automatic test_numbers();
    // first value saturates, vertical tab separates
    send_text("2147483648\v0");
  endtask

  task automatic test_errors();
    send_text("=1 2");                // lone '=' then discarding
    send_text("!");                   // lone '!' right before the terminator
    send_char(8'hFF);                 // unknown character
    send_char(etl_pkg::CH_PLUS);
    send_char(etl_pkg::CH_NUL);
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int n);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = chars_sent + n;
    while (chars_sent < target) send_random_text();
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
      repeat (20) send_text("7+8");
    join
  endtask

  always @(negedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    etl_pkg::token_t got;
    etl_pkg::token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind  = out_tuser;
      got.value = out_tdata[30:0];
      got.pos   = out_tdata[46:31];
      got.ovf   = out_tdata[47];
      got.last  = out_tlast;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d pos %0d", got.kind, got.pos));
      end else begin
        want = tokens_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "kind %0d/%0d value %0d/%0d pos %0d/%0d ovf %b/%b last %b/%b (got/exp)",
            got.kind, want.kind, got.value, want.value, got.pos, want.pos,
            got.ovf, want.ovf, got.last, want.last));
      end
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 81;
    test_operators();
    test_comparisons();
    test_numbers();
    test_errors();

    test_random(14, 81, 140);
    test_random(81, 14, 140);
    test_random(0, 0, 140);
    test_backpressure();

    in_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
